FILE: rtl/core/assert_macros.svh
// Assertion macros for the NOR flash command device checkers.
// Depends on nothing; included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define NFCD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("nfcd check failed");

// Check a property on every clock edge, reset included.
`define NFCD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("nfcd check failed");

`endif

FILE: rtl/core/nfcd_pkg.sv
// Shared types, constants and helpers for the NOR flash command device.
// Depends on nothing; imported by the interfaces, the decoder, the top level and the checker.
package nfcd_pkg;

    // array geometry
    localparam int ADDR_BITS   = 20;
    localparam int SECTOR_BITS = 16;
    localparam int ERASE_BITS  = (SECTOR_BITS >= ADDR_BITS) ? ADDR_BITS : SECTOR_BITS;
    localparam int ARRAY_DEPTH = 1 << ADDR_BITS;

    // bus field widths
    localparam int BUS_ADDR_W = 20;
    localparam int DATA_W     = 8;
    localparam int PHASE_W    = 3;

    localparam logic [ADDR_BITS-1:0] ERASE_MASK =
        ADDR_BITS'((64'd1 << ERASE_BITS) - 64'd1);
    localparam logic [ADDR_BITS-1:0] ARRAY_LAST = {ADDR_BITS{1'b1}};

    // command set constants
    localparam logic [ADDR_BITS-1:0] UNLOCK_ADDR1 = ADDR_BITS'(12'hAAA);
    localparam logic [ADDR_BITS-1:0] UNLOCK_ADDR2 = ADDR_BITS'(12'h555);
    localparam logic [DATA_W-1:0] UNLOCK_DATA1     = 8'hAA;
    localparam logic [DATA_W-1:0] UNLOCK_DATA2     = 8'h55;
    localparam logic [DATA_W-1:0] CMD_ERASE_SETUP  = 8'h80;
    localparam logic [DATA_W-1:0] CMD_PROGRAM      = 8'hA0;
    localparam logic [DATA_W-1:0] CMD_SECTOR_ERASE = 8'h30;
    localparam logic [DATA_W-1:0] ERASED_BYTE      = 8'hFF;

    // bus operations
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // command sequence phases
    localparam logic [PHASE_W-1:0] PH_READ   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_AA1    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_AA2    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_PROG   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_ESETUP = 3'd4;
    localparam logic [PHASE_W-1:0] PH_EAA1   = 3'd5;
    localparam logic [PHASE_W-1:0] PH_EAA2   = 3'd6;

    // decoder verdict for one bus write
    typedef struct packed {
        logic [PHASE_W-1:0] next_phase;
        logic               do_prog;
        logic               do_erase;
        logic               abort;
    } t_cmd_dec;

    // fit a bus address to the array: drop or zero-fill the upper bits
    function automatic logic [ADDR_BITS-1:0] to_array_addr(input logic [BUS_ADDR_W-1:0] a);
        logic [BUS_ADDR_W+ADDR_BITS-1:0] wide;
        wide = {{ADDR_BITS{1'b0}}, a};
        return wide[ADDR_BITS-1:0];
    endfunction

endpackage

FILE: rtl/core/nfcd_req_if.sv
// Bus access channel: valid/ready handshake carrying one read or write beat.
// Depends on nfcd_pkg.
interface nfcd_req_if import nfcd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  operation;
    logic [BUS_ADDR_W-1:0] address;
    logic [DATA_W-1:0]     write_data;

    modport source (output valid, output operation, output address, output write_data,
                    input ready);
    modport sink   (input valid, input operation, input address, input write_data,
                    output ready);
endinterface

FILE: rtl/core/nfcd_rsp_if.sv
// Result channel: valid/ready handshake carrying one result beat per access.
// Depends on nfcd_pkg.
interface nfcd_rsp_if import nfcd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              programmed;
    logic              erased;
    logic              sequence_aborted;

    modport source (output valid, output read_data, output programmed, output erased,
                    output sequence_aborted, input ready);
    modport sink   (input valid, input read_data, input programmed, input erased,
                    input sequence_aborted, output ready);
endinterface

FILE: rtl/core/nfcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module nfcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/nfcd_cmd_dec.sv
// Command sequence decoder: steps the unlock/command phase for one bus write.
// Depends on nfcd_pkg.
module nfcd_cmd_dec import nfcd_pkg::*; (
    input  logic [PHASE_W-1:0]   i_phase,
    input  logic [ADDR_BITS-1:0] i_addr,
    input  logic [DATA_W-1:0]    i_data,
    output t_cmd_dec             o_dec
);
    logic w_at1;
    logic w_at2;

    assign w_at1 = (i_addr == UNLOCK_ADDR1);
    assign w_at2 = (i_addr == UNLOCK_ADDR2);

    always_comb begin
        o_dec = '{next_phase: PH_READ, do_prog: 1'b0, do_erase: 1'b0, abort: 1'b0};
        case (i_phase)
            PH_AA1: begin
                if (w_at2 && i_data == UNLOCK_DATA2) o_dec.next_phase = PH_AA2;
                else                                 o_dec.abort = 1'b1;
            end
            PH_EAA1: begin
                if (w_at2 && i_data == UNLOCK_DATA2) o_dec.next_phase = PH_EAA2;
                else                                 o_dec.abort = 1'b1;
            end
            PH_AA2: begin
                if (w_at1 && i_data == CMD_PROGRAM)          o_dec.next_phase = PH_PROG;
                else if (w_at1 && i_data == CMD_ERASE_SETUP) o_dec.next_phase = PH_ESETUP;
                else                                         o_dec.abort = 1'b1;
            end
            PH_PROG: begin
                o_dec.do_prog = 1'b1;
            end
            PH_ESETUP: begin
                if (w_at1 && i_data == UNLOCK_DATA1) o_dec.next_phase = PH_EAA1;
                else                                 o_dec.abort = 1'b1;
            end
            PH_EAA2: begin
                if (i_data == CMD_SECTOR_ERASE) o_dec.do_erase = 1'b1;
                else                            o_dec.abort = 1'b1;
            end
            default: begin
                // read mode, and the unused codes that behave like it
                if (w_at1 && i_data == UNLOCK_DATA1) o_dec.next_phase = PH_AA1;
                else                                 o_dec.abort = 1'b1;
            end
        endcase
    end
endmodule

FILE: rtl/core/nor_flash_command_device_top.sv
// Byte-wide NOR flash device with the JEDEC unlock/command sequence.
// After reset the block runs a clearing pass that writes 0xFF to every array
// byte, one byte a cycle; it takes no bus beat until that pass is done. It
// then handles one bus beat at a time: a write that only steps the command
// sequence goes from ST_IDLE to ST_DONE, a read or a program goes through
// ST_LOOK as well (the array RAM has a registered read, and a program is
// a read-modify-write through its single write port), and a sector erase
// passes through ST_ERASE, where one sweep counter writes 0xFF to the sector
// one byte a cycle. Each beat gives exactly one result beat. A finished
// result sits in an output register, so the next
// bus beat is taken while it waits; a result that finds that register still
// full holds the sequencer until the sink takes it.
// Depends on nfcd_pkg, nfcd_req_if, nfcd_rsp_if, nfcd_ram and nfcd_cmd_dec.
module nor_flash_command_device_top import nfcd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    nfcd_req_if.sink  i_req,
    nfcd_rsp_if.source o_rsp
);
    // sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;  // power-up clearing pass
    localparam logic [2:0] ST_IDLE  = 3'd1;  // take a bus beat
    localparam logic [2:0] ST_LOOK  = 3'd2;  // array data is back
    localparam logic [2:0] ST_ERASE = 3'd3;  // sweep the sector
    localparam logic [2:0] ST_DONE  = 3'd4;  // hand the result to the output

    logic [2:0]           r_state,  n_state;
    logic [ADDR_BITS-1:0] r_cnt,    n_cnt;
    logic [PHASE_W-1:0]   r_phase,  n_phase;
    logic                 r_op,     n_op;
    logic [ADDR_BITS-1:0] r_addr,   n_addr;
    logic [DATA_W-1:0]    r_wdata,  n_wdata;

    // pending result
    logic [DATA_W-1:0]    r_res_data,  n_res_data;
    logic                 r_res_prog,  n_res_prog;
    logic                 r_res_ers,   n_res_ers;
    logic                 r_res_abort, n_res_abort;

    // output register
    logic                 r_out_valid, n_out_valid;
    logic [DATA_W-1:0]    r_out_data,  n_out_data;
    logic                 r_out_prog,  n_out_prog;
    logic                 r_out_ers,   n_out_ers;
    logic                 r_out_abort, n_out_abort;

    logic                 w_accept;
    logic                 w_out_free;
    logic [ADDR_BITS-1:0] w_in_addr;
    t_cmd_dec             w_dec;

    logic                 w_we;
    logic [ADDR_BITS-1:0] w_waddr;
    logic [DATA_W-1:0]    w_wdata;
    logic                 w_re;
    logic [DATA_W-1:0]    w_rdata;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_in_addr   = to_array_addr(i_req.address);

    nfcd_cmd_dec u_cmd_dec (
        .i_phase (r_phase),
        .i_addr  (w_in_addr),
        .i_data  (i_req.write_data),
        .o_dec   (w_dec)
    );

    nfcd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ARRAY_DEPTH)
    ) u_array (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_in_addr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_phase     = r_phase;
        n_op        = r_op;
        n_addr      = r_addr;
        n_wdata     = r_wdata;
        n_res_data  = r_res_data;
        n_res_prog  = r_res_prog;
        n_res_ers   = r_res_ers;
        n_res_abort = r_res_abort;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_data  = r_out_data;
        n_out_prog  = r_out_prog;
        n_out_ers   = r_out_ers;
        n_out_abort = r_out_abort;
        w_we        = 1'b0;
        w_waddr     = r_cnt;
        w_wdata     = ERASED_BYTE;
        w_re        = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                // fill the whole array with the erased value
                w_we  = 1'b1;
                n_cnt = r_cnt + ADDR_BITS'(1);
                if (r_cnt == ARRAY_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_op        = i_req.operation;
                    n_addr      = w_in_addr;
                    n_wdata     = i_req.write_data;
                    n_res_data  = '0;
                    n_res_prog  = 1'b0;
                    n_res_ers   = 1'b0;
                    n_res_abort = 1'b0;
                    if (i_req.operation == OP_READ) begin
                        w_re    = 1'b1;
                        n_state = ST_LOOK;
                    end else begin
                        n_phase     = w_dec.next_phase;
                        n_res_prog  = w_dec.do_prog;
                        n_res_ers   = w_dec.do_erase;
                        n_res_abort = w_dec.abort;
                        if (w_dec.do_prog) begin
                            // fetch the old byte for the AND
                            w_re    = 1'b1;
                            n_state = ST_LOOK;
                        end else if (w_dec.do_erase) begin
                            n_cnt   = '0;
                            n_state = ST_ERASE;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end
                end
            end
            ST_LOOK: begin
                if (r_op == OP_READ) begin
                    n_res_data = w_rdata;
                end else begin
                    // program can only clear bits
                    w_we    = 1'b1;
                    w_waddr = r_addr;
                    w_wdata = w_rdata & r_wdata;
                end
                n_state = ST_DONE;
            end
            ST_ERASE: begin
                w_we    = 1'b1;
                w_waddr = (r_addr & ~ERASE_MASK) | (r_cnt & ERASE_MASK);
                n_cnt   = r_cnt + ADDR_BITS'(1);
                if ((r_cnt & ERASE_MASK) == ERASE_MASK) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register can take the result
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res_data;
                    n_out_prog  = r_res_prog;
                    n_out_ers   = r_res_ers;
                    n_out_abort = r_res_abort;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cnt       <= '0;
            r_phase     <= PH_READ;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_addr      <= n_addr;
        r_wdata     <= n_wdata;
        r_res_data  <= n_res_data;
        r_res_prog  <= n_res_prog;
        r_res_ers   <= n_res_ers;
        r_res_abort <= n_res_abort;
        r_out_data  <= n_out_data;
        r_out_prog  <= n_out_prog;
        r_out_ers   <= n_out_ers;
        r_out_abort <= n_out_abort;
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.read_data        = r_out_data;
    assign o_rsp.programmed       = r_out_prog;
    assign o_rsp.erased           = r_out_ers;
    assign o_rsp.sequence_aborted = r_out_abort;
endmodule

FILE: rtl/core/nfcd_checker.sv
// Port-level checks for the NOR flash command device, bound to the top level.
// Depends on nfcd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module nfcd_checker import nfcd_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [DATA_W-1:0] i_read_data,
    input logic              i_programmed,
    input logic              i_erased,
    input logic              i_aborted
);
    // a write gives at most one outcome
    `NFCD_ASSERT(a_one_outcome, i_clk, i_rst_n, i_out_valid |-> $countones({i_programmed, i_erased, i_aborted}) <= 1)

    // any flagged outcome came from a write, which returns no data
    `NFCD_ASSERT(a_write_no_data, i_clk, i_rst_n, (i_out_valid && (i_programmed || i_erased || i_aborted)) |-> i_read_data == '0)

    // stalled result beat holds
    `NFCD_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable({i_read_data, i_programmed, i_erased, i_aborted})))

    // one beat at a time: the block is busy right after taking one
    `NFCD_ASSERT(a_busy_after_beat, i_clk, i_rst_n, (i_in_valid && i_in_ready) |=> !i_in_ready)

    // reset starts the clearing pass, so no beat is taken right after it
    `NFCD_ASSERT_ALWAYS(a_clear_after_reset, i_clk, !i_rst_n |=> !i_in_ready)
endmodule

bind nor_flash_command_device_top nfcd_checker u_nfcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_read_data (o_rsp.read_data),
    .i_programmed(o_rsp.programmed),
    .i_erased    (o_rsp.erased),
    .i_aborted   (o_rsp.sequence_aborted)
);
